// File: hw/rtl/coin_change_dispenser_unit_defines.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef COIN_CHANGE_DISPENSER_UNIT_DEFINES_SVH
`define COIN_CHANGE_DISPENSER_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define CCD_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define CCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ccd_pkg.sv
package ccd_pkg;

  // Field widths
  localparam int ActionW = 2;
  localparam int KindW   = 4;
  localparam int CountW  = 8;
  localparam int CashW   = 16;
  localparam int RemW    = 17;
  localparam int DenomW  = 10;
  localparam int StepW   = 3;

  localparam int NUM_COIN_KINDS = 10;
  localparam logic [KindW-1:0] TOP_KIND = 4'd9;
  localparam logic [KindW-1:0] NUM_KINDS_CODE = 4'd10;
  localparam logic [CountW-1:0] STOCK_MAX = 8'hFF;

  // Action codes
  localparam logic [ActionW-1:0] ACT_PURCHASE   = 2'd0;
  localparam logic [ActionW-1:0] ACT_LOAD_PRICE = 2'd1;
  localparam logic [ActionW-1:0] ACT_LOAD_STOCK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_PRICE,
    ST_STOCK,
    ST_PAY,
    ST_EMIT,
    ST_NEXT,
    ST_FINAL
  } ccd_state_t;

  // Request to the payout unit
  typedef struct packed {
    logic              start;
    logic [CashW-1:0]  rem;
    logic [DenomW-1:0] denom;
    logic [CountW-1:0] stock;
  } ccd_pay_req_t;

  // Answer of the payout unit
  typedef struct packed {
    logic              done;
    logic [CountW-1:0] count;
    logic [CashW-1:0]  rem;
  } ccd_pay_rsp_t;

  // Denomination in cents for a coin kind
  function automatic logic [DenomW-1:0] denom_of(input logic [KindW-1:0] kind);
    logic [DenomW-1:0] d;
    unique case (kind)
      4'd0:    d = 10'd1;
      4'd1:    d = 10'd2;
      4'd2:    d = 10'd5;
      4'd3:    d = 10'd10;
      4'd4:    d = 10'd20;
      4'd5:    d = 10'd50;
      4'd6:    d = 10'd100;
      4'd7:    d = 10'd200;
      4'd8:    d = 10'd500;
      4'd9:    d = 10'd1000;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/ccd_req_if.sv
interface ccd_req_if import ccd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [KindW-1:0]   drink_index;
  logic [CashW-1:0]   amount_paid;
  logic [KindW-1:0]   preferred_coin;
  logic [KindW-1:0]   slot_index;
  logic [CashW-1:0]   slot_value;

  modport source (
    output valid, action, drink_index, amount_paid, preferred_coin, slot_index, slot_value,
    input  ready
  );
  modport sink (
    input  valid, action, drink_index, amount_paid, preferred_coin, slot_index, slot_value,
    output ready
  );
endinterface

// File: hw/rtl/ccd_rsp_if.sv
interface ccd_rsp_if import ccd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       coin_index;
  logic [CountW-1:0]      coin_count;
  logic signed [RemW-1:0] remaining_change;
  logic                   is_final;
  logic                   last;

  modport source (
    output valid, coin_index, coin_count, remaining_change, is_final, last,
    input  ready
  );
  modport sink (
    input  valid, coin_index, coin_count, remaining_change, is_final, last,
    output ready
  );
endinterface

// File: hw/rtl/ccd_ram.sv
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ccd_pay_unit.sv
module ccd_pay_unit import ccd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ccd_pay_req_t req,
  output ccd_pay_rsp_t rsp
);

  logic              run;
  logic              done;
  logic [StepW-1:0]  bit_idx;
  logic [CashW-1:0]  rem;
  logic [CountW-1:0] cnt;
  logic [DenomW-1:0] denom;
  logic [CountW-1:0] stock;

  logic [CountW-1:0] trial;
  logic [RemW-1:0]   chunk;
  logic              take;

  // Try one more bit of the coin count: both the stock and the change must allow it
  always_comb begin
    trial = cnt | (CountW'(1) << bit_idx);
    chunk = RemW'(denom) << bit_idx;
    take  = (trial <= stock) && (chunk <= {1'b0, rem});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (bit_idx == '0);
      if (req.start) begin
        run <= 1'b1;
      end else if (run && (bit_idx == '0)) begin
        run <= 1'b0;
      end
    end
  end

  // Datapath: load on start, then one count bit a cycle from the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      bit_idx <= StepW'(CountW - 1);
      rem     <= req.rem;
      cnt     <= '0;
      denom   <= req.denom;
      stock   <= req.stock;
    end else if (run) begin
      bit_idx <= bit_idx - StepW'(1);
      if (take) begin
        cnt <= trial;
        rem <= rem - chunk[CashW-1:0];
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.count = cnt;
  assign rsp.rem   = rem;

endmodule

// File: hw/rtl/coin_change_dispenser_unit.sv
// Change maker with a coin stock, in whole cents. Prices and coin stock live in two
// small RAMs with registered reads; each purchase reads the price, then visits the
// preferred coin kind and the kinds from 1000 cents down to 1 cent, each visit
// reading the stock entry, sizing the payout in a bit-serial unit (one count bit a
// cycle, eight steps) and writing the stock back when coins go out. The walk stops
// early once no change is owed. One beat goes out per kind paid, then a closing beat
// with the change still owed (negative when underpaid); a load gets one acknowledge
// beat. A result beat waits in an output register, so the next item is taken while
// it is held.
module coin_change_dispenser_unit import ccd_pkg::*; #(
  parameter int NUM_DRINKS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ccd_req_if.sink   req,
  ccd_rsp_if.source rsp
);

  localparam int DW = (NUM_DRINKS > 1) ? $clog2(NUM_DRINKS) : 1;

  ccd_state_t state, state_next;

  // Item registers
  logic [CashW-1:0]       paid;
  logic                   drink_ok;
  logic [KindW-1:0]       pref_kind;
  logic [KindW-1:0]       kind, kind_next;
  logic                   pref_phase, pref_phase_next;
  logic signed [RemW-1:0] rem, rem_next;
  logic [CountW-1:0]      stock_q, stock_q_next;
  logic [CountW-1:0]      cnt, cnt_next;

  // Valid bits stand for the zero reset of both tables
  logic [NUM_DRINKS-1:0]     price_vld;
  logic [NUM_COIN_KINDS-1:0] stock_vld;
  logic                      price_hit;
  logic                      stock_hit;

  // Memory ports
  logic              price_we;
  logic [DW-1:0]     price_waddr;
  logic [DW-1:0]     price_raddr;
  logic [CashW-1:0]  price_rdata;
  logic              stock_we;
  logic [KindW-1:0]  stock_waddr;
  logic [CountW-1:0] stock_wdata;
  logic [CountW-1:0] stock_rdata;

  // Payout unit
  ccd_pay_req_t pay_req;
  ccd_pay_rsp_t pay_rsp;

  // Output register
  logic                   rsp_vld;
  logic                   rsp_free;
  logic                   rsp_load;
  logic [KindW-1:0]       rsp_kind, rsp_kind_d;
  logic [CountW-1:0]      rsp_cnt, rsp_cnt_d;
  logic signed [RemW-1:0] rsp_rem, rsp_rem_d;
  logic                   rsp_fin, rsp_fin_d;

  logic                   req_acc;
  logic                   slot_in_drinks;
  logic                   slot_in_kinds;
  logic [CountW-1:0]      stock_load_val;
  logic [CashW-1:0]       price_val;
  logic [CountW-1:0]      stock_val;

  assign req.ready   = (state == ST_IDLE) && !rst;
  assign req_acc     = req.valid && req.ready;
  assign rsp_free    = !rsp_vld || rsp.ready;

  assign price_waddr = DW'(req.slot_index);
  assign price_raddr = DW'(req.drink_index);

  assign slot_in_drinks = (9'(req.slot_index) < 9'(NUM_DRINKS));
  assign slot_in_kinds  = (req.slot_index < NUM_KINDS_CODE);
  assign stock_load_val = (req.slot_value > CashW'(STOCK_MAX)) ? STOCK_MAX
                                                               : req.slot_value[CountW-1:0];

  assign price_val = (drink_ok && price_hit) ? price_rdata : '0;
  assign stock_val = stock_hit ? stock_rdata : '0;

  ccd_ram #(.WIDTH(CashW), .DEPTH(NUM_DRINKS)) u_price_ram (
    .clk   (clk),
    .we    (price_we),
    .waddr (price_waddr),
    .wdata (req.slot_value),
    .raddr (price_raddr),
    .rdata (price_rdata)
  );

  ccd_ram #(.WIDTH(CountW), .DEPTH(NUM_COIN_KINDS)) u_stock_ram (
    .clk   (clk),
    .we    (stock_we),
    .waddr (stock_waddr),
    .wdata (stock_wdata),
    .raddr (kind_next),
    .rdata (stock_rdata)
  );

  ccd_pay_unit u_pay (
    .clk (clk),
    .rst (rst),
    .req (pay_req),
    .rsp (pay_rsp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result beats
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    pref_phase_next = pref_phase;
    rem_next        = rem;
    stock_q_next    = stock_q;
    cnt_next        = cnt;
    price_we        = 1'b0;
    stock_we        = 1'b0;
    stock_waddr     = kind;
    stock_wdata     = stock_q - cnt_next;
    pay_req.start   = 1'b0;
    pay_req.rem     = rem[CashW-1:0];
    pay_req.denom   = denom_of(kind);
    pay_req.stock   = stock_val;
    rsp_load        = 1'b0;
    rsp_kind_d      = '0;
    rsp_cnt_d       = '0;
    rsp_rem_d       = '0;
    rsp_fin_d       = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          unique case (req.action)
            ACT_PURCHASE: begin
              state_next = ST_PRICE;
            end
            ACT_LOAD_PRICE: begin
              price_we   = slot_in_drinks;
              state_next = ST_ACK;
            end
            ACT_LOAD_STOCK: begin
              stock_we    = slot_in_kinds;
              stock_waddr = req.slot_index;
              stock_wdata = stock_load_val;
              state_next  = ST_ACK;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_ACK: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      // Price is back: form the change, then visit the preferred kind, or close when underpaid
      ST_PRICE: begin
        rem_next = $signed({1'b0, paid}) - $signed({1'b0, price_val});
        if (rem_next[RemW-1]) begin
          state_next = ST_FINAL;
        end else begin
          kind_next       = pref_kind;
          pref_phase_next = 1'b1;
          state_next      = ST_STOCK;
        end
      end

      // Stock entry is back: start sizing the payout
      ST_STOCK: begin
        stock_q_next  = stock_val;
        pay_req.start = 1'b1;
        state_next    = ST_PAY;
      end

      // Write the reduced stock back when coins went out
      ST_PAY: begin
        if (pay_rsp.done) begin
          rem_next = $signed({1'b0, pay_rsp.rem});
          cnt_next = pay_rsp.count;
          if (pay_rsp.count != '0) begin
            stock_we    = 1'b1;
            stock_wdata = stock_q - pay_rsp.count;
            state_next  = ST_EMIT;
          end else begin
            state_next = ST_NEXT;
          end
        end
      end

      ST_EMIT: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          rsp_kind_d = kind;
          rsp_cnt_d  = cnt;
          rsp_rem_d  = rem;
          rsp_fin_d  = 1'b0;
          state_next = ST_NEXT;
        end
      end

      // After the preferred kind go to the top kind, then down; close at kind 0 or none owed
      ST_NEXT: begin
        if (rem == '0) begin
          state_next = ST_FINAL;
        end else if (pref_phase) begin
          pref_phase_next = 1'b0;
          kind_next       = TOP_KIND;
          state_next      = ST_STOCK;
        end else if (kind == '0) begin
          state_next = ST_FINAL;
        end else begin
          kind_next  = kind - KindW'(1);
          state_next = ST_STOCK;
        end
      end

      ST_FINAL: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          rsp_rem_d  = rem;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      price_vld <= '0;
      stock_vld <= '0;
      rsp_vld   <= 1'b0;
    end else begin
      if (price_we) begin
        price_vld[price_waddr] <= 1'b1;
      end
      if (stock_we) begin
        stock_vld[stock_waddr] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_vld <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // Item and payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      paid      <= req.amount_paid;
      drink_ok  <= (9'(req.drink_index) < 9'(NUM_DRINKS));
      pref_kind <= (req.preferred_coin < NUM_KINDS_CODE) ? req.preferred_coin : '0;
    end
    // Track the valid bit of each read so that unwritten entries read as zero
    price_hit  <= (9'(req.drink_index) < 9'(NUM_DRINKS)) && price_vld[price_raddr];
    stock_hit  <= stock_vld[kind_next];
    kind       <= kind_next;
    pref_phase <= pref_phase_next;
    rem        <= rem_next;
    stock_q    <= stock_q_next;
    cnt        <= cnt_next;
    if (rsp_load) begin
      rsp_kind <= rsp_kind_d;
      rsp_cnt  <= rsp_cnt_d;
      rsp_rem  <= rsp_rem_d;
      rsp_fin  <= rsp_fin_d;
    end
  end

  assign rsp.valid            = rsp_vld;
  assign rsp.coin_index       = rsp_kind;
  assign rsp.coin_count       = rsp_cnt;
  assign rsp.remaining_change = rsp_rem;
  assign rsp.is_final         = rsp_fin;
  assign rsp.last             = rsp_fin;

endmodule

// File: hw/rtl/ccd_checker.sv
`include "coin_change_dispenser_unit_defines.svh"

module ccd_checker import ccd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [KindW-1:0]       rsp_coin_index,
  input logic [CountW-1:0]      rsp_coin_count,
  input logic signed [RemW-1:0] rsp_remaining_change,
  input logic                   rsp_is_final,
  input logic                   rsp_last
);

  // A stalled result beat keeps its payload
  `CCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coin_index) && $stable(rsp_coin_count) && $stable(rsp_remaining_change) && $stable(rsp_is_final), "result beat changed while stalled")

  // Only closing and acknowledge beats end an item
  `CCD_ASSERT_IMPL(a_final_last, rsp_valid, rsp_is_final == rsp_last, "last differs from is_final")

  // A coin beat pays at least one coin of a real kind and leaves no debt
  `CCD_ASSERT_IMPL(a_coin_beat, rsp_valid && !rsp_is_final, (rsp_coin_count != '0) && !rsp_remaining_change[RemW-1] && (rsp_coin_index <= TOP_KIND), "malformed coin beat")

  // A closing beat names no coin
  `CCD_ASSERT_IMPL(a_close_beat, rsp_valid && rsp_is_final, (rsp_coin_count == '0) && (rsp_coin_index == '0), "closing beat carries coins")

endmodule

bind coin_change_dispenser_unit ccd_checker u_ccd_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_coin_index       (rsp.coin_index),
  .rsp_coin_count       (rsp.coin_count),
  .rsp_remaining_change (rsp.remaining_change),
  .rsp_is_final         (rsp.is_final),
  .rsp_last             (rsp.last)
);

// File: tb/coin_change_dispenser_unit_tb.sv
`timescale 1ns / 100ps

module coin_change_dispenser_unit_tb import ccd_pkg::*; ();

  localparam int DRINKS = 16;
  localparam int RUN_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 160;
  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;
  localparam int COIN_CENTS [NUM_COIN_KINDS] = '{1, 2, 5, 10, 20, 50, 100, 200, 500, 1000};

  typedef struct {
    logic [ActionW-1:0] action;
    logic [KindW-1:0]   drink;
    logic [CashW-1:0]   paid;
    logic [KindW-1:0]   pref;
    logic [KindW-1:0]   slot;
    logic [CashW-1:0]   value;
  } vend_item_t;

  typedef struct {
    logic [KindW-1:0]       kind;
    logic [CountW-1:0]      count;
    logic signed [RemW-1:0] owed;
    logic                   is_final;
    logic                   last;
  } payout_beat_t;

  logic clk;
  logic rst;

  ccd_req_if req ();
  ccd_rsp_if rsp ();

  coin_change_dispenser_unit #(.NUM_DRINKS(DRINKS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copies of the price and coin stock memories
  logic [CashW-1:0]  price_mem [DRINKS];
  logic [CountW-1:0] stock_mem [NUM_COIN_KINDS];
  payout_beat_t      owed_beats [$];

  int unsigned errors;
  int unsigned cycles;
  bit          tx_gaps;
  bit          rx_gaps;
  int unsigned rx_hold;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("coin_change_dispenser_unit_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycles, got, want);
  endtask

  // Work out the beats that one accepted item causes, updating the shadow state
  function automatic void predict_payout(input vend_item_t it);
    payout_beat_t beat;
    int           owed;
    int unsigned  kind;
    int unsigned  n;
    beat = '{kind: '0, count: '0, owed: '0, is_final: 1'b1, last: 1'b1};
    case (it.action)
      ACT_LOAD_PRICE: begin
        if (it.slot < DRINKS) price_mem[it.slot] = it.value;
        owed_beats.push_back(beat);
      end
      ACT_LOAD_STOCK: begin
        if (it.slot < NUM_COIN_KINDS)
          stock_mem[it.slot] = (it.value > STOCK_MAX) ? STOCK_MAX : it.value[CountW-1:0];
        owed_beats.push_back(beat);
      end
      ACT_PURCHASE: begin
        owed = int'(it.paid) - ((it.drink < DRINKS) ? int'(price_mem[it.drink]) : 0);
        // preferred kind first, then largest to smallest
        for (int step = 0; step <= NUM_COIN_KINDS; step++) begin
          if (step == 0) kind = (it.pref < NUM_COIN_KINDS) ? 32'(it.pref) : 0;
          else kind = NUM_COIN_KINDS - step;
          n = 0;
          while (owed >= COIN_CENTS[kind] && stock_mem[kind] != 0) begin
            owed -= COIN_CENTS[kind];
            stock_mem[kind]--;
            n++;
          end
          if (n != 0) begin
            owed_beats.push_back('{kind: kind[KindW-1:0], count: n[CountW-1:0],
                                   owed: owed[RemW-1:0], is_final: 1'b0, last: 1'b0});
          end
        end
        beat.owed = owed[RemW-1:0];
        owed_beats.push_back(beat);
      end
      default: ;
    endcase
  endfunction

  // Offer one item, after a random gap when tx_gaps is set, and hold it until the beat is taken
  task automatic send_item(input vend_item_t it);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.action         = it.action;
    req.drink_index    = it.drink;
    req.amount_paid    = it.paid;
    req.preferred_coin = it.pref;
    req.slot_index     = it.slot;
    req.slot_value     = it.value;
    req.valid          = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_payout(it);
  endtask

  task automatic send_fields(input logic [ActionW-1:0] action, input int drink, input int paid,
                             input int pref, input int slot, input int value);
    vend_item_t it;
    it.action = action;
    it.drink  = drink[KindW-1:0];
    it.paid   = paid[CashW-1:0];
    it.pref   = pref[KindW-1:0];
    it.slot   = slot[KindW-1:0];
    it.value  = value[CashW-1:0];
    send_item(it);
  endtask

  // Drop valid and hold the sender until every owed beat has come back
  task automatic wait_drained();
    @(negedge clk);
    req.valid = 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  // Draw a random item: mostly purchases near the stored price, some loads and noise
  function automatic vend_item_t draw_item();
    vend_item_t  it;
    int unsigned pick;
    int unsigned price;
    int unsigned paid;
    pick      = $urandom_range(0, 99);
    it.drink  = KindW'($urandom_range(0, 15));
    it.pref   = KindW'($urandom_range(0, 15));
    it.slot   = KindW'($urandom_range(0, 15));
    it.value  = CashW'($urandom);
    it.paid   = CashW'($urandom);
    if (pick < 9) begin
      it.action = ACT_LOAD_PRICE;
      if ($urandom_range(0, 3) != 0) it.value = CashW'($urandom_range(0, 2000));
    end else if (pick < 22) begin
      it.action = ACT_LOAD_STOCK;
      if ($urandom_range(0, 3) != 0) it.slot = KindW'($urandom_range(0, 9));
      case ($urandom_range(0, 5))
        0:       it.value = CashW'($urandom_range(0, 300));
        1:       ;
        default: it.value = CashW'($urandom_range(0, 25));
      endcase
    end else if (pick < 25) begin
      it.action = ACT_UNUSED;
    end else begin
      it.action = ACT_PURCHASE;
      price = 32'(price_mem[it.drink]);
      case ($urandom_range(0, 19))
        0, 1, 2: ;
        3, 4: begin
          if (price != 0) it.paid = CashW'($urandom_range(0, price - 1));
        end
        default: begin
          paid = price + $urandom_range(0, 2500);
          it.paid = (paid > 65535) ? 16'hFFFF : paid[CashW-1:0];
        end
      endcase
    end
    return it;
  endfunction

  // Loads: table extremes, saturation, slots beyond the stock table, unused action
  task automatic test_table_loads();
    send_fields(ACT_LOAD_PRICE, 0, 0, 0, 15, 65535);
    send_fields(ACT_LOAD_PRICE, 0, 0, 0, 0, 0);
    send_fields(ACT_LOAD_PRICE, 0, 0, 0, 1, 150);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 0, 65535);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 9, 3);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 5, 2);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 15, 300);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 10, 7);
    send_fields(ACT_UNUSED, 15, 65535, 15, 15, 65535);
  endtask

  // Purchases: underpaid, full stock of one kind, exact pay, preferred kinds
  task automatic test_change_cases();
    send_fields(ACT_PURCHASE, 15, 0, 0, 0, 0);
    send_fields(ACT_PURCHASE, 0, 65535, 15, 0, 0);
    send_fields(ACT_PURCHASE, 1, 150, 4, 0, 0);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 3, 12);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 6, 256);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 0, 40);
    send_fields(ACT_PURCHASE, 1, 1000, 3, 0, 0);
    send_fields(ACT_PURCHASE, 1, 1234, 12, 0, 0);
    send_fields(ACT_PURCHASE, 1, 149, 9, 0, 0);
    send_fields(ACT_PURCHASE, 15, 65535, 6, 15, 65535);
    send_fields(ACT_LOAD_STOCK, 0, 0, 0, 9, 255);
    send_fields(ACT_PURCHASE, 0, 65535, 9, 0, 0);
    wait_drained();
  endtask

  // Stall the receiver for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold = 400;
    repeat (14) send_item(draw_item());
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    vend_item_t  it;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      it = draw_item();
      send_item(it);
      if (it.action != ACT_UNUSED) sent++;
    end
  endtask

  // Random traffic in phases with different idling on either side
  task automatic test_random_traffic();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_random_phase(55);
    wait_drained();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random_phase(30);
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    run_random_phase(25);
    tx_gaps = 1'b1;
    rx_gaps = 1'b0;
    run_random_phase(25);
  endtask

  // Receiver: stall a random number of cycles before each beat, or a long hold on request
  initial begin : rx_side
    int unsigned stall;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 8) : 0;
      end
      if (stall != 0) begin
        rsp.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready = 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready) && rx_hold == 0);
    end
  end

  // Compare each accepted beat with the oldest owed one
  always @(posedge clk) begin : beat_check
    payout_beat_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_beats.size() == 0) begin
        report_mismatch("beat with nothing owed, coin_index", int'(rsp.coin_index), 0);
      end else begin
        want = owed_beats.pop_front();
        if (rsp.coin_index !== want.kind)
          report_mismatch("coin_index", int'(rsp.coin_index), int'(want.kind));
        if (rsp.coin_count !== want.count)
          report_mismatch("coin_count", int'(rsp.coin_count), int'(want.count));
        if (rsp.remaining_change !== want.owed)
          report_mismatch("remaining_change", int'(rsp.remaining_change), int'(want.owed));
        if (rsp.is_final !== want.is_final)
          report_mismatch("is_final", int'(rsp.is_final), int'(want.is_final));
        if (rsp.last !== want.last)
          report_mismatch("last", int'(rsp.last), int'(want.last));
      end
    end
  end

  initial begin
    errors  = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    rx_hold = 0;
    rst     = 1'b1;
    req.valid          = 1'b0;
    req.action         = ACT_PURCHASE;
    req.drink_index    = '0;
    req.amount_paid    = '0;
    req.preferred_coin = '0;
    req.slot_index     = '0;
    req.slot_value     = '0;
    foreach (price_mem[i]) price_mem[i] = '0;
    foreach (stock_mem[i]) stock_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_loads();
    test_change_cases();
    test_backpressure();
    test_random_traffic();

    // Drop valid, let the last beats drain and give the block time to settle
    @(negedge clk);
    req.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("coin_change_dispenser_unit_tb: clean");
    end else begin
      $display("coin_change_dispenser_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ccd_pkg.sv
hw/rtl/ccd_req_if.sv
hw/rtl/ccd_rsp_if.sv
hw/rtl/ccd_ram.sv
hw/rtl/ccd_pay_unit.sv
hw/rtl/coin_change_dispenser_unit.sv
hw/rtl/ccd_checker.sv
tb/coin_change_dispenser_unit_tb.sv
